/* rtl/forth_control_flow_unit_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Forth control-flow unit.
// Each macro checks on the rising edge of clk and is disabled during reset.
// ---------------------------------------------------------------------------
`ifndef FORTH_CONTROL_FLOW_UNIT_TOP_MACROS_SVH
`define FORTH_CONTROL_FLOW_UNIT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCFU_ASSERT_NOW(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fcfu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FCFU_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fcfu assertion failed");

`endif

/* rtl/fcfu_pkg.sv */
// ---------------------------------------------------------------------------
// fcfu_pkg
// Types, command and error codes, and field widths shared by the Forth
// control-flow unit.
// ---------------------------------------------------------------------------
package fcfu_pkg;

    // Field widths fixed by the transaction format.
    localparam int CMD_W   = 5;
    localparam int CELL_W  = 64;
    localparam int IP_W    = 16;
    localparam int COUNT_W = 6;
    localparam int ERR_W   = 3;

    // Number of top stack entries the execute logic looks at.
    localparam int D_VIEW = 2;
    localparam int R_VIEW = 8;

    // Control words.
    typedef enum logic [CMD_W-1:0] {
        CMD_CALL      = 5'd0,
        CMD_EXIT      = 5'd1,
        CMD_LIT       = 5'd2,
        CMD_BRANCH    = 5'd3,
        CMD_EQ0BRANCH = 5'd4,
        CMD_0BRANCH   = 5'd5,
        CMD_Q0BRANCH  = 5'd6,
        CMD_NEXT      = 5'd7,
        CMD_DO        = 5'd8,
        CMD_LOOP      = 5'd9,
        CMD_PLOOP     = 5'd10,
        CMD_LEAVE     = 5'd11,
        CMD_QLEAVE    = 5'd12,
        CMD_I         = 5'd13,
        CMD_J         = 5'd14,
        CMD_K         = 5'd15,
        CMD_RFETCH    = 5'd16,
        CMD_TOR       = 5'd17,
        CMD_RFROM     = 5'd18,
        CMD_2RFETCH   = 5'd19,
        CMD_2TOR      = 5'd20,
        CMD_2RFROM    = 5'd21,
        CMD_RDROP     = 5'd22,
        CMD_2RDROP    = 5'd23
    } fcfu_cmd_t;

    // Fault codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_DATA_UNDER = 3'd1,
        ERR_DATA_OVER  = 3'd2,
        ERR_RET_UNDER  = 3'd3,
        ERR_RET_OVER   = 3'd4
    } fcfu_err_t;

    // Input transaction.
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [CELL_W-1:0] operand;
    } fcfu_cmd_pkt_t;

    // Result transaction.
    typedef struct packed {
        logic [IP_W-1:0]          next_ip;
        logic signed [CELL_W-1:0] data_top;
        logic [COUNT_W-1:0]       data_count;
        logic [COUNT_W-1:0]       return_count;
        logic [ERR_W-1:0]         error;
    } fcfu_result_t;

    // Stack update decided by the execute logic. A shift moves every entry
    // down (positive) or up (negative); pushed values then overwrite the top.
    typedef struct packed {
        fcfu_err_t          err;
        logic signed [2:0]  d_shift;
        logic [1:0]         d_push;
        logic signed [2:0]  r_shift;
        logic [1:0]         r_push;
        logic [CELL_W-1:0]  d_val0;
        logic [CELL_W-1:0]  d_val1;
        logic [CELL_W-1:0]  r_val0;
        logic [CELL_W-1:0]  r_val1;
        logic [CELL_W-1:0]  r_val2;
    } fcfu_step_t;

endpackage

/* rtl/fcfu_exec.sv */
// ---------------------------------------------------------------------------
// fcfu_exec
// Decodes one control word, checks the stack needs in fault order, and
// produces the stack update and the next instruction pointer.
// ---------------------------------------------------------------------------
module fcfu_exec #(
    parameter int DATA_DEPTH   = 32,
    parameter int RETURN_DEPTH = 32,
    parameter int ADDR_BITS    = 16
) (
    input  fcfu_pkg::fcfu_cmd_pkt_t               cmd,
    input  logic [ADDR_BITS-1:0]                  ip,
    input  logic [$clog2(DATA_DEPTH+1)-1:0]       d_count,
    input  logic [$clog2(RETURN_DEPTH+1)-1:0]     r_count,
    input  logic [fcfu_pkg::CELL_W-1:0]           d_top [fcfu_pkg::D_VIEW],
    input  logic [fcfu_pkg::CELL_W-1:0]           r_top [fcfu_pkg::R_VIEW],
    output fcfu_pkg::fcfu_step_t                  step,
    output logic [ADDR_BITS-1:0]                  nip
);
    import fcfu_pkg::*;

    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);

    logic [ADDR_BITS-1:0] ip1;
    logic [ADDR_BITS-1:0] ip2;
    logic [ADDR_BITS-1:0] tgt;
    logic [CELL_W-1:0]    r0_inc;
    logic [CELL_W-1:0]    r0_dec;
    logic [CELL_W-1:0]    r0_add;
    logic                 d0_zero;
    logic [1:0]           d_req;
    logic [1:0]           d_up;
    logic [3:0]           r_req;
    logic [1:0]           r_up;
    logic                 d_under;
    logic                 d_over;
    logic                 r_under;
    logic                 r_over;
    fcfu_step_t           act;
    logic [ADDR_BITS-1:0] act_nip;

    // Shared address and loop arithmetic.
    assign ip1     = ip + ADDR_BITS'(1);
    assign ip2     = ip + ADDR_BITS'(2);
    assign tgt     = cmd.operand[ADDR_BITS-1:0];
    assign r0_inc  = r_top[0] + CELL_W'(1);
    assign r0_dec  = r_top[0] - CELL_W'(1);
    assign r0_add  = r_top[0] + d_top[0];
    assign d0_zero = (d_top[0] == '0);

    // Entries each word needs on the stacks and how many it adds.
    always_comb
    begin
        d_req = 2'd0;
        d_up  = 2'd0;
        r_req = 4'd0;
        r_up  = 2'd0;
        case (cmd.command) inside
            CMD_EQ0BRANCH, CMD_0BRANCH, CMD_Q0BRANCH, CMD_PLOOP, CMD_QLEAVE, CMD_TOR:
                d_req = 2'd1;
            CMD_DO, CMD_2TOR:
                d_req = 2'd2;
            default: ;
        endcase
        case (cmd.command) inside
            CMD_LIT, CMD_I, CMD_J, CMD_K, CMD_RFETCH, CMD_RFROM: d_up = 2'd1;
            CMD_2RFETCH, CMD_2RFROM:                             d_up = 2'd2;
            default: ;
        endcase
        case (cmd.command) inside
            CMD_EXIT, CMD_NEXT, CMD_RFETCH, CMD_RFROM, CMD_RDROP: r_req = 4'd1;
            CMD_I, CMD_2RFETCH, CMD_2RFROM, CMD_2RDROP:          r_req = 4'd2;
            CMD_LOOP, CMD_PLOOP, CMD_LEAVE:                      r_req = 4'd3;
            CMD_QLEAVE: r_req = d0_zero ? 4'd0 : 4'd3;
            CMD_J:      r_req = 4'd5;
            CMD_K:      r_req = 4'd8;
            default: ;
        endcase
        case (cmd.command) inside
            CMD_CALL, CMD_TOR: r_up = 2'd1;
            CMD_2TOR:          r_up = 2'd2;
            CMD_DO:            r_up = 2'd3;
            default: ;
        endcase
    end

    // Fault checks; only pushes can overflow, and a word underflows when it reads or pops more entries than are there.
    assign d_under = d_count < DCW'(d_req);
    assign d_over  = ({1'b0, d_count} + (DCW+1)'(d_up)) > (DCW+1)'(DATA_DEPTH);
    assign r_under = r_count < RCW'(r_req);
    assign r_over  = ({1'b0, r_count} + (RCW+1)'(r_up)) > (RCW+1)'(RETURN_DEPTH);

    // Effect of each word when no fault is found.
    always_comb
    begin
        act     = '0;
        act.err = ERR_OK;
        act_nip = ip1;
        case (cmd.command)
            CMD_CALL:
            begin
                act.r_shift = 3'sd1;
                act.r_push  = 2'd1;
                act.r_val0  = CELL_W'(ip1);
                act_nip     = tgt;
            end
            CMD_EXIT:
            begin
                act.r_shift = -3'sd1;
                act_nip     = r_top[0][ADDR_BITS-1:0];
            end
            CMD_LIT:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = cmd.operand;
                act_nip     = ip2;
            end
            CMD_BRANCH:
                act_nip = tgt;
            CMD_EQ0BRANCH:
                act_nip = d0_zero ? tgt : ip2;
            CMD_0BRANCH:
            begin
                act.d_shift = -3'sd1;
                act_nip     = d0_zero ? tgt : ip2;
            end
            CMD_Q0BRANCH:
            begin
                if (d0_zero)
                begin
                    act.d_shift = -3'sd1;
                    act_nip     = tgt;
                end
                else
                begin
                    act_nip = ip2;
                end
            end
            CMD_NEXT:
            begin
                if (r0_dec == '0)
                begin
                    act.r_shift = -3'sd1;
                    act_nip     = ip2;
                end
                else
                begin
                    act.r_push = 2'd1;
                    act.r_val0 = r0_dec;
                    act_nip    = tgt;
                end
            end
            CMD_DO:
            begin
                act.d_shift = -3'sd2;
                act.r_shift = 3'sd3;
                act.r_push  = 2'd3;
                act.r_val0  = d_top[0] - d_top[1];
                act.r_val1  = d_top[1];
                act.r_val2  = cmd.operand;
                act_nip     = ip2;
            end
            CMD_LOOP:
            begin
                if (r0_inc == '0)
                begin
                    act.r_shift = -3'sd3;
                    act_nip     = ip2;
                end
                else
                begin
                    act.r_push = 2'd1;
                    act.r_val0 = r0_inc;
                    act_nip    = tgt;
                end
            end
            CMD_PLOOP:
            begin
                // The loop ends when the index sum crosses zero in sign.
                act.d_shift = -3'sd1;
                if ((r0_add[CELL_W-1] ^ r_top[0][CELL_W-1]) == 1'b1)
                begin
                    act.r_shift = -3'sd3;
                    act_nip     = ip2;
                end
                else
                begin
                    act.r_push = 2'd1;
                    act.r_val0 = r0_add;
                    act_nip    = tgt;
                end
            end
            CMD_LEAVE:
            begin
                act.r_shift = -3'sd3;
                act_nip     = r_top[2][ADDR_BITS-1:0];
            end
            CMD_QLEAVE:
            begin
                act.d_shift = -3'sd1;
                if (!d0_zero)
                begin
                    act.r_shift = -3'sd3;
                    act_nip     = r_top[2][ADDR_BITS-1:0];
                end
            end
            CMD_I:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = r_top[0] + r_top[1];
            end
            CMD_J:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = r_top[3] + r_top[4];
            end
            CMD_K:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = r_top[6] + r_top[7];
            end
            CMD_RFETCH:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = r_top[0];
            end
            CMD_TOR:
            begin
                act.d_shift = -3'sd1;
                act.r_shift = 3'sd1;
                act.r_push  = 2'd1;
                act.r_val0  = d_top[0];
            end
            CMD_RFROM:
            begin
                act.d_shift = 3'sd1;
                act.d_push  = 2'd1;
                act.d_val0  = r_top[0];
                act.r_shift = -3'sd1;
            end
            CMD_2RFETCH:
            begin
                act.d_shift = 3'sd2;
                act.d_push  = 2'd2;
                act.d_val0  = r_top[0];
                act.d_val1  = r_top[1];
            end
            CMD_2TOR:
            begin
                act.d_shift = -3'sd2;
                act.r_shift = 3'sd2;
                act.r_push  = 2'd2;
                act.r_val0  = d_top[0];
                act.r_val1  = d_top[1];
            end
            CMD_2RFROM:
            begin
                act.d_shift = 3'sd2;
                act.d_push  = 2'd2;
                act.d_val0  = r_top[0];
                act.d_val1  = r_top[1];
                act.r_shift = -3'sd2;
            end
            CMD_RDROP:
                act.r_shift = -3'sd1;
            CMD_2RDROP:
                act.r_shift = -3'sd2;
            default: ;
        endcase
    end

    // A fault leaves every stack and the pointer as they are.
    always_comb
    begin
        step = act;
        nip  = act_nip;
        if (d_under || d_over || r_under || r_over)
        begin
            step         = '0;
            nip          = ip;
            if (d_under)
                step.err = ERR_DATA_UNDER;
            else if (d_over)
                step.err = ERR_DATA_OVER;
            else if (r_under)
                step.err = ERR_RET_UNDER;
            else
                step.err = ERR_RET_OVER;
        end
    end

endmodule

/* rtl/forth_control_flow_unit_top.sv */
// ---------------------------------------------------------------------------
// forth_control_flow_unit_top
// Forth threaded-code control words: instruction pointer, data stack and
// return stack, one control word per transaction.
//
//   Channel   Handshake               Payload
//   cmd       cmd_valid / cmd_ready   cmd    (command, operand)
//   result    result_valid / ready    result (next_ip, data_top, counts, error)
//
// A command is captured in an input register and executed once the result
// register is free or being emptied; its result is then visible in the result
// register. One command per cycle is sustained while results are taken, set by
// the single execute stage that updates the stacks.
// Reset clears the pointer, both depths and all valid flags; stack contents
// are not reset. A stalled result holds the execute stage and then the input.
// ---------------------------------------------------------------------------
`include "forth_control_flow_unit_top_macros.svh"

module forth_control_flow_unit_top #(
    parameter int DATA_DEPTH   = 32,
    parameter int RETURN_DEPTH = 32,
    parameter int ADDR_BITS    = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  fcfu_pkg::fcfu_cmd_pkt_t cmd,
    output logic                    result_valid,
    input  logic                    result_ready,
    output fcfu_pkg::fcfu_result_t  result
);
    import fcfu_pkg::*;

    localparam int DCW = $clog2(DATA_DEPTH + 1);
    localparam int RCW = $clog2(RETURN_DEPTH + 1);

    logic                 s1_valid_reg;
    fcfu_cmd_pkt_t        s1_reg;
    logic                 out_valid_reg;
    fcfu_result_t         out_reg;
    fcfu_result_t         out_next;
    logic [ADDR_BITS-1:0] ip_reg;
    logic [DCW-1:0]       d_count_reg;
    logic [DCW-1:0]       d_count_next;
    logic [RCW-1:0]       r_count_reg;
    logic [RCW-1:0]       r_count_next;
    logic [CELL_W-1:0]    d_stack_reg  [DATA_DEPTH];
    logic [CELL_W-1:0]    d_stack_next [DATA_DEPTH];
    logic [CELL_W-1:0]    r_stack_reg  [RETURN_DEPTH];
    logic [CELL_W-1:0]    r_stack_next [RETURN_DEPTH];
    logic [CELL_W-1:0]    d_top [D_VIEW];
    logic [CELL_W-1:0]    r_top [R_VIEW];
    fcfu_step_t           step;
    logic [ADDR_BITS-1:0] nip;
    logic                 exec_fire;
    logic                 cmd_fire;
    logic                 fault_fire;
    logic                 state_kept;
    logic                 counts_match;

    // Handshake: execute when the result register can take a new transaction.
    assign exec_fire    = s1_valid_reg && (!out_valid_reg || result_ready);
    assign cmd_ready    = !s1_valid_reg || exec_fire;
    assign cmd_fire     = cmd_valid && cmd_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Fixed views of the stack tops.
    assign d_top[0] = d_stack_reg[0];
    assign d_top[1] = d_stack_reg[1];
    for (genvar gv = 0; gv < R_VIEW; gv++)
    begin : g_rview
        assign r_top[gv] = r_stack_reg[gv];
    end

    fcfu_exec #(
        .DATA_DEPTH   (DATA_DEPTH),
        .RETURN_DEPTH (RETURN_DEPTH),
        .ADDR_BITS    (ADDR_BITS)
    ) u_exec (
        .cmd     (s1_reg),
        .ip      (ip_reg),
        .d_count (d_count_reg),
        .r_count (r_count_reg),
        .d_top   (d_top),
        .r_top   (r_top),
        .step    (step),
        .nip     (nip)
    );

    // Depths after the step.
    assign d_count_next = d_count_reg + DCW'(step.d_shift);
    assign r_count_next = r_count_reg + RCW'(step.r_shift);

    // Data stack entries: shift, then overwrite the pushed top entries.
    for (genvar gi = 0; gi < DATA_DEPTH; gi++)
    begin : g_dstk
        localparam int UP1 = (gi + 1 < DATA_DEPTH) ? gi + 1 : gi;
        localparam int UP2 = (gi + 2 < DATA_DEPTH) ? gi + 2 : gi;
        localparam int DN1 = (gi >= 1) ? gi - 1 : gi;
        localparam int DN2 = (gi >= 2) ? gi - 2 : gi;

        always_comb
        begin
            d_stack_next[gi] = d_stack_reg[gi];
            case (step.d_shift)
                -3'sd2:  d_stack_next[gi] = d_stack_reg[UP2];
                -3'sd1:  d_stack_next[gi] = d_stack_reg[UP1];
                3'sd1:   d_stack_next[gi] = d_stack_reg[DN1];
                3'sd2:   d_stack_next[gi] = d_stack_reg[DN2];
                default: ;
            endcase
            if (gi == 0 && step.d_push >= 2'd1)
                d_stack_next[gi] = step.d_val0;
            if (gi == 1 && step.d_push >= 2'd2)
                d_stack_next[gi] = step.d_val1;
        end
    end

    // Return stack entries, same scheme with up to three places.
    for (genvar gi = 0; gi < RETURN_DEPTH; gi++)
    begin : g_rstk
        localparam int UP1 = (gi + 1 < RETURN_DEPTH) ? gi + 1 : gi;
        localparam int UP2 = (gi + 2 < RETURN_DEPTH) ? gi + 2 : gi;
        localparam int UP3 = (gi + 3 < RETURN_DEPTH) ? gi + 3 : gi;
        localparam int DN1 = (gi >= 1) ? gi - 1 : gi;
        localparam int DN2 = (gi >= 2) ? gi - 2 : gi;
        localparam int DN3 = (gi >= 3) ? gi - 3 : gi;

        always_comb
        begin
            r_stack_next[gi] = r_stack_reg[gi];
            case (step.r_shift)
                -3'sd3:  r_stack_next[gi] = r_stack_reg[UP3];
                -3'sd2:  r_stack_next[gi] = r_stack_reg[UP2];
                -3'sd1:  r_stack_next[gi] = r_stack_reg[UP1];
                3'sd1:   r_stack_next[gi] = r_stack_reg[DN1];
                3'sd2:   r_stack_next[gi] = r_stack_reg[DN2];
                3'sd3:   r_stack_next[gi] = r_stack_reg[DN3];
                default: ;
            endcase
            if (gi == 0 && step.r_push >= 2'd1)
                r_stack_next[gi] = step.r_val0;
            if (gi == 1 && step.r_push >= 2'd2)
                r_stack_next[gi] = step.r_val1;
            if (gi == 2 && step.r_push >= 2'd3)
                r_stack_next[gi] = step.r_val2;
        end
    end

    // Result transaction assembled from the state after the step.
    always_comb
    begin
        out_next.next_ip      = IP_W'(nip);
        out_next.data_top     = (d_count_next != '0) ? d_stack_next[0] : '0;
        out_next.data_count   = COUNT_W'(d_count_next);
        out_next.return_count = COUNT_W'(r_count_next);
        out_next.error        = step.err;
    end

    // Control state: valid flags, pointer and depths.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ip_reg        <= '0;
            d_count_reg   <= '0;
            r_count_reg   <= '0;
        end
        else
        begin
            if (cmd_fire)
                s1_valid_reg <= 1'b1;
            else if (exec_fire)
                s1_valid_reg <= 1'b0;

            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            if (exec_fire)
            begin
                ip_reg      <= nip;
                d_count_reg <= d_count_next;
                r_count_reg <= r_count_next;
            end
        end
    end

    // Payload registers and stack contents.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
            s1_reg <= cmd;
        if (exec_fire)
        begin
            out_reg      <= out_next;
            d_stack_reg  <= d_stack_next;
            r_stack_reg  <= r_stack_next;
        end
    end

    // Conditions watched by the assertions.
    assign fault_fire   = exec_fire && (step.err != ERR_OK);
    assign state_kept   = (nip == ip_reg) && (d_count_next == d_count_reg)
                          && (r_count_next == r_count_reg);
    assign counts_match = (result.data_count == COUNT_W'(d_count_reg))
                          && (result.return_count == COUNT_W'(r_count_reg));

    // A faulting command leaves pointer and depths untouched.
    `FCFU_ASSERT_NOW(a_fault_no_change, fault_fire, state_kept)
    // A pending result always reports the current stack depths.
    `FCFU_ASSERT_NOW(a_result_counts, out_valid_reg, counts_match)
    // The input stalls only behind a held command and a blocked result.
    `FCFU_ASSERT_NOW(a_stall_cause, !cmd_ready, s1_valid_reg && out_valid_reg && !result_ready)

endmodule

/* tb/sv/forth_cf_checker.sv */
// ----------------------------------------------------------------------------
// Forth control-flow unit checker
// Watches both channels, keeps its own copy of the instruction pointer and
// of both stacks, predicts the result of every accepted command and compares
// each accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module forth_cf_checker #(
    parameter int DATA_DEPTH   = 32,
    parameter int RETURN_DEPTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    input  logic                    cmd_ready,
    input  fcfu_pkg::fcfu_cmd_pkt_t cmd,
    input  logic                    result_valid,
    input  logic                    result_ready,
    input  fcfu_pkg::fcfu_result_t  result,
    output int                      mismatch_count,
    output int                      pending,
    output int                      data_depth_now,
    output int                      return_depth_now
);
    timeunit 1ns;
    timeprecision 1ps;

    import fcfu_pkg::*;

    // Shadow machine state.
    logic [IP_W-1:0]   ip_now;
    logic [CELL_W-1:0] data_cells [DATA_DEPTH];
    logic [CELL_W-1:0] ret_cells [RETURN_DEPTH];
    int                dsp;
    int                rsp;

    // Predicted results, oldest first.
    fcfu_result_t predicted_results [$];

    function automatic logic [CELL_W-1:0] data_at(int k);
        return data_cells[dsp - 1 - k];
    endfunction

    function automatic logic [CELL_W-1:0] ret_at(int k);
        return ret_cells[rsp - 1 - k];
    endfunction

    function automatic void push_data(logic [CELL_W-1:0] v);
        data_cells[dsp] = v;
        dsp++;
    endfunction

    function automatic logic [CELL_W-1:0] pop_data();
        dsp--;
        return data_cells[dsp];
    endfunction

    function automatic void push_ret(logic [CELL_W-1:0] v);
        ret_cells[rsp] = v;
        rsp++;
    endfunction

    function automatic logic [CELL_W-1:0] pop_ret();
        rsp--;
        return ret_cells[rsp];
    endfunction

    // Executes one control word on the shadow state and forms its result.
    task automatic execute_word(input fcfu_cmd_pkt_t c, output fcfu_result_t r);
        logic [CMD_W-1:0]  code;
        logic [CELL_W-1:0] opnd;
        logic [CELL_W-1:0] a;
        logic [CELL_W-1:0] b;
        logic [CELL_W-1:0] sum;
        logic [IP_W-1:0]   ip1;
        logic [IP_W-1:0]   ip2;
        logic [IP_W-1:0]   tgt;
        logic [IP_W-1:0]   nip;
        int                dreq;
        int                rreq;
        int                dd;
        int                rd;
        fcfu_err_t         fault;

        code  = c.command;
        opnd  = c.operand;
        ip1   = ip_now + 1'b1;
        ip2   = ip_now + 2'd2;
        tgt   = opnd[IP_W-1:0];
        nip   = ip1;
        dreq  = 0;
        rreq  = 0;
        dd    = 0;
        rd    = 0;
        fault = ERR_OK;

        // Data stack needs come first.
        case (code)
            CMD_EQ0BRANCH, CMD_0BRANCH, CMD_Q0BRANCH, CMD_PLOOP, CMD_QLEAVE,
            CMD_TOR: dreq = 1;
            CMD_DO, CMD_2TOR: dreq = 2;
            default: dreq = 0;
        endcase
        if (dsp < dreq)
        begin
            fault = ERR_DATA_UNDER;
        end
        else
        begin
            case (code)
                CMD_LIT, CMD_I, CMD_J, CMD_K, CMD_RFETCH, CMD_RFROM: dd = 1;
                CMD_2RFETCH, CMD_2RFROM: dd = 2;
                CMD_0BRANCH, CMD_PLOOP, CMD_QLEAVE, CMD_TOR: dd = -1;
                CMD_DO, CMD_2TOR: dd = -2;
                CMD_Q0BRANCH: dd = (data_at(0) == 0) ? -1 : 0;
                default: dd = 0;
            endcase
            if (dsp + dd > DATA_DEPTH)
                fault = ERR_DATA_OVER;
        end

        // Return stack needs; loop and leave words of a do frame need a full three-cell frame.
        if (fault == ERR_OK)
        begin
            case (code)
                CMD_EXIT, CMD_NEXT, CMD_RFETCH, CMD_RFROM, CMD_RDROP: rreq = 1;
                CMD_I, CMD_2RFETCH, CMD_2RFROM, CMD_2RDROP: rreq = 2;
                CMD_LOOP, CMD_PLOOP, CMD_LEAVE: rreq = 3;
                CMD_QLEAVE: rreq = (data_at(0) != 0) ? 3 : 0;
                CMD_J: rreq = 5;
                CMD_K: rreq = 8;
                default: rreq = 0;
            endcase
            if (rsp < rreq)
            begin
                fault = ERR_RET_UNDER;
            end
            else
            begin
                case (code)
                    CMD_CALL, CMD_TOR: rd = 1;
                    CMD_2TOR: rd = 2;
                    CMD_DO: rd = 3;
                    CMD_EXIT, CMD_RFROM, CMD_RDROP: rd = -1;
                    CMD_2RFROM, CMD_2RDROP: rd = -2;
                    CMD_LEAVE: rd = -3;
                    CMD_QLEAVE: rd = (data_at(0) != 0) ? -3 : 0;
                    CMD_NEXT: rd = (ret_at(0) - 1 == 0) ? -1 : 0;
                    CMD_LOOP: rd = (ret_at(0) + 1 == 0) ? -3 : 0;
                    CMD_PLOOP:
                    begin
                        a   = ret_at(0);
                        sum = a + data_at(0);
                        rd  = (sum[CELL_W-1] != a[CELL_W-1]) ? -3 : 0;
                    end
                    default: rd = 0;
                endcase
                if (rsp + rd > RETURN_DEPTH)
                    fault = ERR_RET_OVER;
            end
        end

        // A faulting word leaves everything as it was.
        if (fault == ERR_OK)
        begin
            case (code)
                CMD_CALL:
                begin
                    push_ret(CELL_W'(ip1));
                    nip = tgt;
                end
                CMD_EXIT:
                begin
                    a   = pop_ret();
                    nip = a[IP_W-1:0];
                end
                CMD_LIT:
                begin
                    push_data(opnd);
                    nip = ip2;
                end
                CMD_BRANCH: nip = tgt;
                CMD_EQ0BRANCH: nip = (data_at(0) == 0) ? tgt : ip2;
                CMD_0BRANCH: nip = (pop_data() == 0) ? tgt : ip2;
                CMD_Q0BRANCH:
                begin
                    if (data_at(0) == 0)
                    begin
                        a   = pop_data();
                        nip = tgt;
                    end
                    else
                    begin
                        nip = ip2;
                    end
                end
                CMD_NEXT:
                begin
                    ret_cells[rsp-1] = ret_cells[rsp-1] - 1;
                    if (ret_at(0) == 0)
                    begin
                        rsp--;
                        nip = ip2;
                    end
                    else
                    begin
                        nip = tgt;
                    end
                end
                CMD_DO:
                begin
                    a = data_at(1);
                    b = data_at(0);
                    dsp -= 2;
                    push_ret(opnd);
                    push_ret(a);
                    push_ret(b - a);
                    nip = ip2;
                end
                CMD_LOOP:
                begin
                    ret_cells[rsp-1] = ret_cells[rsp-1] + 1;
                    if (ret_at(0) == 0)
                    begin
                        rsp -= 3;
                        nip = ip2;
                    end
                    else
                    begin
                        nip = tgt;
                    end
                end
                CMD_PLOOP:
                begin
                    b   = pop_data();
                    a   = ret_at(0);
                    sum = a + b;
                    ret_cells[rsp-1] = sum;
                    if (sum[CELL_W-1] != a[CELL_W-1])
                    begin
                        rsp -= 3;
                        nip = ip2;
                    end
                    else
                    begin
                        nip = tgt;
                    end
                end
                CMD_LEAVE:
                begin
                    a   = ret_at(2);
                    nip = a[IP_W-1:0];
                    rsp -= 3;
                end
                CMD_QLEAVE:
                begin
                    if (pop_data() != 0)
                    begin
                        a   = ret_at(2);
                        nip = a[IP_W-1:0];
                        rsp -= 3;
                    end
                end
                CMD_I: push_data(ret_at(0) + ret_at(1));
                CMD_J: push_data(ret_at(3) + ret_at(4));
                CMD_K: push_data(ret_at(6) + ret_at(7));
                CMD_RFETCH: push_data(ret_at(0));
                CMD_TOR: push_ret(pop_data());
                CMD_RFROM: push_data(pop_ret());
                CMD_2RFETCH:
                begin
                    a = ret_at(1);
                    b = ret_at(0);
                    push_data(a);
                    push_data(b);
                end
                CMD_2TOR:
                begin
                    a = data_at(1);
                    b = data_at(0);
                    dsp -= 2;
                    push_ret(a);
                    push_ret(b);
                end
                CMD_2RFROM:
                begin
                    a = ret_at(1);
                    b = ret_at(0);
                    push_data(a);
                    push_data(b);
                    rsp -= 2;
                end
                CMD_RDROP: rsp -= 1;
                CMD_2RDROP: rsp -= 2;
                default: nip = ip1;
            endcase
            ip_now = nip;
        end

        r.next_ip      = ip_now;
        r.data_top     = (dsp != 0) ? data_at(0) : '0;
        r.data_count   = COUNT_W'(dsp);
        r.return_count = COUNT_W'(rsp);
        r.error        = fault;
    endtask

    // Predict on every accepted command, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        fcfu_result_t want;
        if (!rst_n)
        begin
            ip_now = '0;
            dsp    = 0;
            rsp    = 0;
            for (int n = 0; n < DATA_DEPTH; n++)
                data_cells[n] = '0;
            for (int n = 0; n < RETURN_DEPTH; n++)
                ret_cells[n] = '0;
            predicted_results.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
            begin
                execute_word(cmd, want);
                predicted_results.push_back(want);
            end
            if (result_valid && result_ready)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transaction with no command pending: %p",
                                 $realtime, result);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result.next_ip !== want.next_ip
                        || result.data_top !== want.data_top
                        || result.data_count !== want.data_count
                        || result.return_count !== want.return_count
                        || result.error !== want.error)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result mismatch: expected %p, actual %p",
                                     $realtime, want, result);
                    end
                end
            end
        end
        pending          = predicted_results.size();
        data_depth_now   = dsp;
        return_depth_now = rsp;
    end

endmodule

/* tb/sv/tb_forth_control_flow_unit_top.sv */
// ----------------------------------------------------------------------------
// Forth control-flow unit testbench
// Drives control words into the unit: a directed pass over every command and
// the stack faults, then well-formed loop, call and stack sequences with
// random content mixed with noise, under three sender/receiver idle patterns
// and a long receiver stall in each. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_forth_control_flow_unit_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fcfu_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 360;
    localparam int HOLD_CYCLES     = 120;
    localparam logic [CMD_W-1:0] LAST_CODE    = '1;
    localparam logic [CMD_W-1:0] FIRST_UNUSED = CMD_W'(CMD_2RDROP + 1);

    // Enough pushes to run past a full stack from empty.
    localparam int DATA_DEPTH_FILL = 34;

    logic          clk;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_ready;
    fcfu_cmd_pkt_t cmd;
    logic          result_valid;
    logic          result_ready;
    fcfu_result_t  result;

    int mismatch_count;
    int pending;
    int data_depth_now;
    int return_depth_now;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int words_sent;
    int cycles;

    forth_control_flow_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    forth_cf_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd),
        .result_valid     (result_valid),
        .result_ready     (result_ready),
        .result           (result),
        .mismatch_count   (mismatch_count),
        .pending          (pending),
        .data_depth_now   (data_depth_now),
        .return_depth_now (return_depth_now)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_forth_control_flow_unit_top NOT OK");
        $finish;
    end

    // Result side: random idling, plus one long stall per hold request.
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready = 1'b0;
                hold_left--;
            end
            else if (hold_seen != hold_requests)
            begin
                hold_seen    = hold_requests;
                hold_left    = HOLD_CYCLES;
                result_ready = 1'b0;
            end
            else
            begin
                result_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Random cell, biased toward zero, small values and the extremes.
    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return {1'b0, {(CELL_W-1){1'b1}}};
            3: return {1'b1, {(CELL_W-1){1'b0}}};
            4: return CELL_W'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] any_cell();
        return {$urandom, $urandom};
    endfunction

    // Offers one command transaction and waits for its acceptance.
    task automatic send_word(input logic [CMD_W-1:0] code, input logic [CELL_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd       = '{command: code, operand: value};
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Pauses until every result is in, then pops both stacks down.
    task automatic drain_stacks();
        int d_left;
        int r_left;
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        d_left = data_depth_now;
        r_left = return_depth_now;
        if ($urandom_range(0, 1))
        begin
            d_left = (d_left > 3) ? $urandom_range(0, 3) : 0;
            r_left = (r_left > 3) ? $urandom_range(0, 3) : 0;
        end
        repeat (data_depth_now - d_left)
            send_word(CMD_0BRANCH, any_cell());
        repeat (return_depth_now - r_left)
            send_word(CMD_RDROP, any_cell());
    endtask

    // One well-formed sequence with random content, or some noise.
    task automatic run_random_sequence();
        logic [CELL_W-1:0] base;
        int                n;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // Counted do/loop that runs out after n passes.
                n    = $urandom_range(1, 4);
                base = pick_cell();
                send_word(CMD_LIT, base);
                send_word(CMD_LIT, base - n);
                send_word(CMD_DO, any_cell());
                repeat (n)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        send_word(CMD_I, any_cell());
                        send_word(CMD_0BRANCH, any_cell());
                    end
                    send_word(CMD_LOOP, any_cell());
                end
            end
            2:
            begin
                // Three nested frames, index words, then both kinds of leave.
                repeat (3)
                begin
                    base = pick_cell();
                    send_word(CMD_LIT, base);
                    send_word(CMD_LIT, base - 2);
                    send_word(CMD_DO, any_cell());
                end
                send_word(CMD_K, any_cell());
                send_word(CMD_J, any_cell());
                send_word(CMD_I, any_cell());
                repeat (3)
                    send_word(CMD_0BRANCH, any_cell());
                send_word(CMD_LIT, any_cell() | 1);
                send_word(CMD_QLEAVE, any_cell());
                send_word(CMD_LIT, '0);
                send_word(CMD_QLEAVE, any_cell());
                send_word(CMD_LEAVE, any_cell());
                send_word(CMD_LEAVE, any_cell());
            end
            3:
            begin
                // +loop with steps that may or may not cross the sign boundary.
                send_word(CMD_LIT, pick_cell());
                send_word(CMD_LIT, pick_cell());
                send_word(CMD_DO, any_cell());
                repeat ($urandom_range(1, 4))
                begin
                    send_word(CMD_LIT, pick_cell());
                    send_word(CMD_PLOOP, any_cell());
                end
            end
            4:
            begin
                // for/next.
                n = $urandom_range(1, 4);
                send_word(CMD_LIT, CELL_W'(n));
                send_word(CMD_TOR, any_cell());
                repeat (n)
                    send_word(CMD_NEXT, any_cell());
            end
            5:
            begin
                // Nested calls and their returns.
                n = $urandom_range(1, 4);
                repeat (n)
                    send_word(CMD_CALL, any_cell());
                if ($urandom_range(0, 1))
                begin
                    send_word(CMD_RFETCH, any_cell());
                    send_word(CMD_0BRANCH, any_cell());
                end
                repeat (n)
                    send_word(CMD_EXIT, any_cell());
            end
            6:
            begin
                // Return stack moves.
                send_word(CMD_LIT, pick_cell());
                send_word(CMD_LIT, pick_cell());
                send_word(CMD_2TOR, any_cell());
                send_word(CMD_2RFETCH, any_cell());
                send_word(CMD_2RFROM, any_cell());
                send_word(CMD_TOR, any_cell());
                send_word(CMD_RFETCH, any_cell());
                send_word(CMD_RFROM, any_cell());
                send_word(CMD_2TOR, any_cell());
                if ($urandom_range(0, 1))
                    send_word(CMD_2RDROP, any_cell());
                else
                    send_word(CMD_RDROP, any_cell());
            end
            7:
            begin
                // Conditional branches on zero and nonzero tops.
                send_word(CMD_LIT, $urandom_range(0, 1) ? '0 : pick_cell());
                send_word(CMD_EQ0BRANCH, any_cell());
                send_word(CMD_0BRANCH, any_cell());
                send_word(CMD_LIT, $urandom_range(0, 1) ? '0 : pick_cell());
                send_word(CMD_Q0BRANCH, any_cell());
                send_word(CMD_BRANCH, any_cell());
            end
            8:
            begin
                // Noise: any code, any operand.
                repeat ($urandom_range(1, 4))
                    send_word(CMD_W'($urandom_range(0, LAST_CODE)), any_cell());
            end
            default:
            begin
                // Unused codes, now and then a burst that overflows a stack.
                case ($urandom_range(0, 9))
                    0: repeat (DATA_DEPTH_FILL) send_word(CMD_LIT, any_cell());
                    1: repeat (DATA_DEPTH_FILL) send_word(CMD_CALL, any_cell());
                    default:
                        send_word(CMD_W'($urandom_range(FIRST_UNUSED, LAST_CODE)),
                                  any_cell());
                endcase
            end
        endcase
    endtask

    // Stimulus.
    initial
    begin
        int phase_start;
        int seq_count;
        bit held;
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        send_idle_pct = 35;
        recv_idle_pct = 51;
        hold_requests = 0;
        words_sent    = 0;
        seq_count     = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed pass: faults on empty stacks, extremes, every command.
        send_word(CMD_EXIT, any_cell());
        send_word(CMD_0BRANCH, any_cell());
        send_word(LAST_CODE, '1);
        send_word(CMD_LIT, {1'b0, {(CELL_W-1){1'b1}}});
        send_word(CMD_LIT, {1'b1, {(CELL_W-1){1'b0}}});
        send_word(CMD_2TOR, '0);
        send_word(CMD_2RFROM, '0);
        send_word(CMD_DO, '1);
        send_word(CMD_K, '0);
        send_word(CMD_J, '0);
        send_word(CMD_I, '0);
        send_word(CMD_PLOOP, 64'h10);
        send_word(CMD_QLEAVE, '0);
        send_word(CMD_TOR, '0);
        send_word(CMD_LOOP, '0);
        send_word(CMD_CALL, '1);
        send_word(CMD_2RFETCH, '0);
        send_word(CMD_RFETCH, '0);
        send_word(CMD_TOR, '0);
        send_word(CMD_RFROM, '0);
        send_word(CMD_RDROP, '0);
        send_word(CMD_EXIT, '0);
        send_word(CMD_2RDROP, '0);
        send_word(CMD_EQ0BRANCH, 64'h1234);
        send_word(CMD_Q0BRANCH, '1);
        send_word(CMD_BRANCH, {$urandom, $urandom});
        send_word(CMD_NEXT, '0);
        send_word(CMD_LEAVE, '0);
        drain_stacks();

        // Random part under three idle patterns.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_start = words_sent;
            held        = 1'b0;
            while (words_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (seq_count % 6 == 5)
                    drain_stacks();
                else
                    run_random_sequence();
                seq_count++;
                if (!held && words_sent - phase_start > 40)
                begin
                    hold_requests++;
                    held = 1'b1;
                end
            end
            drain_stacks();
        end

        // Let the last results come out, then wait idle before the verdict.
        @(negedge clk);
        cmd_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0 && pending == 0)
            $display("tb_forth_control_flow_unit_top OK");
        else
            $display("tb_forth_control_flow_unit_top NOT OK");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/fcfu_pkg.sv
rtl/fcfu_exec.sv
rtl/forth_control_flow_unit_top.sv
tb/sv/forth_cf_checker.sv
tb/sv/tb_forth_control_flow_unit_top.sv
